// ----- hw/rtl/sem_pkg.sv -----
package sem_pkg;

    // Fixed field widths
    localparam int PIX_W  = 8;   // grey sample and magnitude
    localparam int CFG_W  = 12;  // frame size registers
    localparam int ROW_W  = 12;  // row counter
    localparam int GRAD_W = 11;  // signed Sobel gradient, |g| <= 1020
    localparam int SQ_W   = 20;  // g*g <= 1040400
    localparam int SUM_W  = SQ_W + 1;
    localparam int RAD_W  = 16;  // radicand below the saturation point
    localparam int ROOT_W = 8;
    localparam int REM_W  = ROOT_W + 3;
    localparam int NSTEP  = RAD_W / 2;

    // Frame size limits and reset values
    localparam logic [CFG_W-1:0] DIM_MIN      = 12'd3;
    localparam logic [CFG_W-1:0] HEIGHT_MAX   = 12'd4095;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam int               INTERIOR_START = 2;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // Sideband that rides along the square-root pipeline
    typedef struct packed {
        logic sat;
        logic last;
    } t_sqrt_tag;

endpackage

// ----- hw/rtl/sem_ram.sv -----
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sem_isqrt.sv -----
// Pipelined floored square root, one root bit per stage (restoring method).
module sem_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sem_pkg::RAD_W-1:0]     i_rad,
    input  sem_pkg::t_sqrt_tag            i_tag,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sem_pkg::ROOT_W-1:0]    o_root,
    output sem_pkg::t_sqrt_tag            o_tag
);

    localparam int NSTEP  = sem_pkg::NSTEP;
    localparam int RAD_W  = sem_pkg::RAD_W;
    localparam int ROOT_W = sem_pkg::ROOT_W;
    localparam int REM_W  = sem_pkg::REM_W;

    logic [NSTEP:0]      r_valid;
    logic [NSTEP+1:0]    w_ready;
    logic [RAD_W-1:0]    r_rad  [NSTEP+1];
    logic [REM_W-1:0]    r_rem  [NSTEP+1];
    logic [ROOT_W-1:0]   r_root [NSTEP+1];
    sem_pkg::t_sqrt_tag  r_tag  [NSTEP+1];

    assign w_ready[NSTEP+1] = i_ready;
    assign o_ready          = w_ready[0];

    // Input stage: hold the radicand, clear remainder and root
    assign w_ready[0] = !r_valid[0] || w_ready[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (w_ready[0]) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0] && i_valid) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        assign w_ready[k] = !r_valid[k] || w_ready[k+1];

        always_comb begin
            rem_sh = {r_rem[k-1][REM_W-3:0], r_rad[k-1][RAD_W-1 -: 2]};
            trial  = {{(REM_W-ROOT_W-2){1'b0}}, r_root[k-1], 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[k-1][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_ready[k]) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[k] && r_valid[k-1]) begin
                r_rad[k]  <= {r_rad[k-1][RAD_W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_valid[NSTEP];
    assign o_root  = r_tag[NSTEP].sat ? '1 : r_root[NSTEP];
    assign o_tag   = r_tag[NSTEP];

endmodule

// ----- hw/rtl/sobel_edge_magnitude_top.sv -----
// Sobel edge magnitude over a 3x3 window.
//
// Pixels of a frame enter on the s_axis channel in raster order, one 8-bit
// grey sample per transaction. For each interior pixel (not on the frame
// border) one transaction leaves on m_axis: the floored magnitude
// sqrt(gx*gx + gy*gy), saturated at 255, with tlast set on the last interior
// pixel of the frame. Border pixels yield no output transaction.
// Frame width and height are set through the write port (index 0 width,
// index 1 height) while the block is idle; values are clamped to 3..MAX_WIDTH
// and 3..4095.
// Throughput: one pixel per clock while m_axis keeps up. The two rows above
// the current one live in one dual-port RAM, read at the pixel's column on
// acceptance and written back as stage 1 fires; the column schedule keeps
// any read at least three pixels away from the pending write of that column.
// On its way a result passes stage 1 (RAM read), the gradient and squares
// stages, the square-root input register and eight square-root stages.
// Reset clears the pixel position, window and all pipeline valids; RAM
// contents stay undefined until rows write them; earlier reads feed no result.
// When m_axis stalls, the pipeline fills its empty stages before s_axis_tready
// drops; nothing is lost or repeated.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream: tdata[7:0] = pixel
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,
    // master stream: tdata[7:0] = magnitude, tlast = frame_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    output logic                        m_axis_tlast,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam int PIX_W  = sem_pkg::PIX_W;
    localparam int CFG_W  = sem_pkg::CFG_W;
    localparam int ROW_W  = sem_pkg::ROW_W;
    localparam int GRAD_W = sem_pkg::GRAD_W;
    localparam int SQ_W   = sem_pkg::SQ_W;
    localparam int SUM_W  = sem_pkg::SUM_W;
    localparam int RAD_W  = sem_pkg::RAD_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
    localparam logic [CFG_W-1:0] WIDTH_CAP =
        CFG_W'((MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH);

    // ---------------------------------------------------------------
    // Configuration: store the clamped frame size
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CFG_W-1:0] n_width_clamped;
    logic [CFG_W-1:0] n_height_clamped;

    always_comb begin
        if (i_cfg_wdata < sem_pkg::DIM_MIN) begin
            n_width_clamped = sem_pkg::DIM_MIN;
        end else if (i_cfg_wdata > WIDTH_CAP) begin
            n_width_clamped = WIDTH_CAP;
        end else begin
            n_width_clamped = i_cfg_wdata;
        end
        // upper limit of the height equals the register's full range
        if (i_cfg_wdata < sem_pkg::DIM_MIN) begin
            n_height_clamped = sem_pkg::DIM_MIN;
        end else if (i_cfg_wdata > sem_pkg::HEIGHT_MAX) begin
            n_height_clamped = sem_pkg::HEIGHT_MAX;
        end else begin
            n_height_clamped = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sem_pkg::WIDTH_RESET;
            r_frame_height <= sem_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (sem_pkg::t_cfg_reg'(i_cfg_index))
                sem_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= n_width_clamped;
                sem_pkg::CFG_FRAME_HEIGHT: r_frame_height <= n_height_clamped;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Position counters, advanced on each accepted pixel
    // ---------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] width_ext;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic             pos_interior;
    logic             pos_last;
    logic             in_accept;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign col_inc      = CMP_W'(r_col) + CMP_W'(1);
    assign width_ext    = CMP_W'(r_frame_width);
    assign row_inc      = {1'b0, r_row} + (ROW_W+1)'(1);
    assign col_wrap     = col_inc >= width_ext;
    assign row_wrap     = row_inc >= {1'b0, r_frame_height};
    assign pos_interior = (CMP_W'(r_col) >= CMP_W'(sem_pkg::INTERIOR_START))
                       && (r_row >= ROW_W'(sem_pkg::INTERIOR_START));
    assign pos_last     = (col_inc == width_ext) && (row_inc == {1'b0, r_frame_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Line buffer RAM: [15:8] two rows up, [7:0] one row up
    // ---------------------------------------------------------------
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] ram_wdata;
    logic               ram_we;

    sem_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Stage 1: column read back; update window and write the RAM back
    // ---------------------------------------------------------------
    logic             r_s1_valid;
    logic             r_s1_res;
    logic             r_s1_last;
    logic [PIX_W-1:0] r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    logic [PIX_W-1:0] r_win [6];  // 0..2 left column t/m/b, 3..5 centre column
    logic             s1_fire;
    logic             s2_ready;
    logic [PIX_W-1:0] col_top;
    logic [PIX_W-1:0] col_mid;

    assign col_top       = ram_rdata[2*PIX_W-1:PIX_W];
    assign col_mid       = ram_rdata[PIX_W-1:0];
    assign s1_fire       = r_s1_valid && (!r_s1_res || s2_ready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign ram_we        = s1_fire;
    assign ram_wdata     = {col_mid, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_res  <= pos_interior;
            r_s1_last <= pos_last;
            r_s1_pix  <= s_axis_tdata;
            r_s1_addr <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= col_top;
            r_win[4] <= col_mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // Gradients of the window centered one row up, one column left
    logic signed [GRAD_W-1:0] e_top, e_mid, e_bot, e_lt, e_lm, e_lb, e_mt, e_mb;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;

    assign e_top  = $signed({{(GRAD_W-PIX_W){1'b0}}, col_top});
    assign e_mid  = $signed({{(GRAD_W-PIX_W){1'b0}}, col_mid});
    assign e_bot  = $signed({{(GRAD_W-PIX_W){1'b0}}, r_s1_pix});
    assign e_lt   = $signed({{(GRAD_W-PIX_W){1'b0}}, r_win[0]});
    assign e_lm   = $signed({{(GRAD_W-PIX_W){1'b0}}, r_win[1]});
    assign e_lb   = $signed({{(GRAD_W-PIX_W){1'b0}}, r_win[2]});
    assign e_mt   = $signed({{(GRAD_W-PIX_W){1'b0}}, r_win[3]});
    assign e_mb   = $signed({{(GRAD_W-PIX_W){1'b0}}, r_win[5]});
    assign grad_x = (e_top - e_lt) + ((e_mid - e_lm) <<< 1) + (e_bot - e_lb);
    assign grad_y = (e_lb - e_lt) + ((e_mb - e_mt) <<< 1) + (e_bot - e_top);

    // ---------------------------------------------------------------
    // Stage 2: registered gradients (interior pixels only)
    // ---------------------------------------------------------------
    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic                     s3_ready;

    assign s2_ready = !r_s2_valid || s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid && r_s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid && r_s1_res) begin
            r_gx      <= grad_x;
            r_gy      <= grad_y;
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squares
    // ---------------------------------------------------------------
    logic                       r_s3_valid;
    logic                       r_s3_last;
    logic [SQ_W-1:0]            r_sqx;
    logic [SQ_W-1:0]            r_sqy;
    logic signed [2*GRAD_W-1:0] prod_x;
    logic signed [2*GRAD_W-1:0] prod_y;
    logic [SUM_W-1:0]           sq_sum;
    logic                       sqrt_in_ready;
    sem_pkg::t_sqrt_tag         sqrt_in_tag;
    sem_pkg::t_sqrt_tag         sqrt_out_tag;

    assign prod_x   = r_gx * r_gx;
    assign prod_y   = r_gy * r_gy;
    assign s3_ready = !r_s3_valid || sqrt_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_sqx     <= prod_x[SQ_W-1:0];
            r_sqy     <= prod_y[SQ_W-1:0];
            r_s3_last <= r_s2_last;
        end
    end

    // Sum and split: anything at or above 2^16 saturates to 255
    assign sq_sum           = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign sqrt_in_tag.sat  = |sq_sum[SUM_W-1:RAD_W];
    assign sqrt_in_tag.last = r_s3_last;

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .o_ready (sqrt_in_ready),
        .i_rad   (sq_sum[RAD_W-1:0]),
        .i_tag   (sqrt_in_tag),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_root  (m_axis_tdata),
        .o_tag   (sqrt_out_tag)
    );

    assign m_axis_tlast = sqrt_out_tag.last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_ram_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && in_accept) |-> (r_s1_addr != r_col))
        else $error("line RAM read and write hit the same column");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && col_wrap && row_wrap) |=> (r_col == '0 && r_row == '0))
        else $error("position counters did not restart at frame end");

    a_s2_from_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s2_valid) |-> $past(r_s1_valid && r_s1_res))
        else $error("gradient stage loaded from a border pixel");

endmodule

// ----- tb/tb_sobel_edge_magnitude_top.sv -----
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_top;
    import sem_pkg::*;

    localparam int MAX_W           = 2048;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the pipeline
    localparam int QUIET_LIMIT     = 4000;  // cycles without any transaction
    localparam int DRAIN_CYCLES    = 24;    // beyond the pixel-to-result latency
    localparam int RANDOM_PIXELS   = 1300;
    localparam int REPORT_LIMIT    = 10;

    // Three 3x3 probe frames in raster order:
    //   hard vertical edge 0 -> 255, gradient saturates far above 255;
    //   gx = 255, gy = 1, root floors to exactly 255 without saturating;
    //   gx = 256, gy = 0, energy hits 65536, the first saturated value.
    localparam logic [0:26][7:0] PROBE_PIXELS = {
        8'd0, 8'd128, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd128, 8'd255,
        8'd0, 8'd0,   8'd63,  8'd0, 8'd0,   8'd64,  8'd0, 8'd0,   8'd64,
        8'd0, 8'd0,   8'd64,  8'd0, 8'd0,   8'd64,  8'd0, 8'd0,   8'd64
    };

    typedef enum int {
        TEX_NOISE,  // full-range random samples
        TEX_SOFT,   // flat area with small jitter, gives small magnitudes
        TEX_RAMP,   // linear slope that wraps, mostly moderate gradients
        TEX_STEP    // two levels split at a random column
    } texture_e;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             frame_end;
    } edge_result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;     // [7:0] pixel
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;          // [7:0] magnitude
    logic              m_axis_tlast;          // frame_end
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    // Stimulus and scoreboard storage
    logic [7:0]        pixel_queue[$];
    edge_result_t      expected_edges[$];
    int unsigned       pixels_queued = 0;
    int unsigned       results_seen = 0;
    int unsigned       failures = 0;
    int unsigned       quiet_cycles = 0;

    // Flow control knobs shared between the sequencer and the bus processes
    logic              steady_flow = 1'b0;
    int unsigned       hold_off_requests = 0;
    int unsigned       hold_offs_done = 0;
    int unsigned       hold_left = 0;

    // Predictor state: its own line stores, window, position and frame size
    logic [7:0]        line_prev  [0:MAX_W-1];
    logic [7:0]        line_prev2 [0:MAX_W-1];
    logic [7:0]        window_px  [0:5];   // left col top/mid/bot, centre col top/mid/bot
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;

    sobel_edge_magnitude_top #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Frame size as the block uses it: register value clamped into range
    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] value, int unsigned top_limit);
        if (value < DIM_MIN)
            return DIM_MIN;
        if (value > top_limit)
            return top_limit;
        return value;
    endfunction

    function automatic int unsigned active_width();
        return clamp_dim(width_reg, MAX_W);
    endfunction

    function automatic int unsigned active_height();
        return clamp_dim(height_reg, HEIGHT_MAX);
    endfunction

    // Floored square root, pinned at 255 once the energy reaches 256*256
    function automatic logic [PIX_W-1:0] floor_root_sat(int unsigned energy);
        int unsigned root;
        if (energy >= 32'd65536)
            return 8'd255;
        root = 0;
        while ((root + 1) * (root + 1) <= energy)
            root++;
        return root[PIX_W-1:0];
    endfunction

    // Advance the predictor by one accepted pixel; queue the edge result, if any
    function automatic void predict_edge(logic [7:0] pixel);
        int unsigned  w, h, ci;
        int           top, mid, bot, lt, lm, lb, mt, mb, gx, gy;
        edge_result_t res;
        w   = active_width();
        h   = active_height();
        ci  = (col_pos < MAX_W) ? col_pos : 0;
        top = line_prev2[ci];
        mid = line_prev[ci];
        bot = pixel;
        lt  = window_px[0];
        lm  = window_px[1];
        lb  = window_px[2];
        mt  = window_px[3];
        mb  = window_px[5];

        // Only interior centres (two columns and two rows in) give a result
        if (col_pos >= INTERIOR_START && row_pos >= INTERIOR_START) begin
            gx = (top - lt) + 2 * (mid - lm) + (bot - lb);
            gy = (lb - lt) + 2 * (mb - mt) + (bot - top);
            res.magnitude = floor_root_sat(gx * gx + gy * gy);
            res.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
            expected_edges.push_back(res);
        end

        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = top[7:0];
        window_px[4] = mid[7:0];
        window_px[5] = pixel;
        line_prev2[ci] = mid[7:0];
        line_prev[ci]  = pixel;

        // A position at or past a shrunken size wraps on the next pixel
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // Pixels still needed to bring the position back to the top-left corner
    function automatic int unsigned pixels_to_frame_start();
        int unsigned c, r, w, h, n;
        c = col_pos;
        r = row_pos;
        w = active_width();
        h = active_height();
        n = 0;
        do begin
            n++;
            if (c + 1 >= w) begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                c++;
            end
        end while (c != 0 || r != 0);
        return n;
    endfunction

    function automatic void note_failure(string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // Queue a run of pixels with a texture; positions follow the given row width
    task automatic queue_pixels(int unsigned count, int unsigned width, texture_e tex);
        int unsigned base, spread, dx, dy, split, x, y, v;
        logic [7:0]  level_a, level_b;
        base    = $urandom_range(255);
        spread  = $urandom_range(1, 24);
        dx      = $urandom_range(0, 40);
        dy      = $urandom_range(0, 40);
        split   = $urandom_range(0, width - 1);
        level_a = $urandom;
        level_b = $urandom;
        for (int unsigned i = 0; i < count; i++) begin
            x = i % width;
            y = i / width;
            case (tex)
                TEX_NOISE: begin
                    v = $urandom_range(255);
                end
                TEX_SOFT: begin
                    v = base + $urandom_range(spread);
                    if (v > 255)
                        v = 255;
                end
                TEX_RAMP: begin
                    v = (base + x * dx + y * dy) % 256;
                end
                default: begin
                    v = (x >= split) ? level_a : level_b;
                end
            endcase
            pixel_queue.push_back(v[7:0]);
        end
        pixels_queued += count;
    endtask

    // Wait until every pixel is sent, every expected result is out and the pipeline is empty
    task automatic wait_for_quiet();
        while (pixel_queue.size() != 0 || s_axis_tvalid || expected_edges.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_reg(t_cfg_reg which, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (which == CFG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    // Drain, set a new frame size, then stream whole frames of random texture
    task automatic run_frames(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val,
                              int unsigned frames);
        wait_for_quiet();
        write_frame_reg(CFG_FRAME_WIDTH, w_val);
        write_frame_reg(CFG_FRAME_HEIGHT, h_val);
        for (int unsigned f = 0; f < frames; f++)
            queue_pixels(active_width() * active_height(), active_width(),
                         texture_e'($urandom_range(3)));
    endtask

    // Sender: present the next pending pixel once the current transaction is
    // done; unless steady flow is on, it idles instead with a chance of 36 in 100.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 36)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random backpressure, plus a long hold-off on request that only
    // starts while a result is waiting, so the pipeline backs up into s_axis.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_off_requests != hold_offs_done && m_axis_tvalid) begin
            m_axis_tready  <= 1'b0;
            hold_left      <= HOLD_OFF_CYCLES;
            hold_offs_done <= hold_offs_done + 1;
        end else begin
            m_axis_tready <= steady_flow || ($urandom_range(99) >= 36);
        end
    end

    // Monitor: predict on every accepted pixel, check every accepted result
    // against the oldest expectation.
    always @(posedge i_clk) begin
        edge_result_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_edge(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                if (expected_edges.size() == 0) begin
                    note_failure($sformatf("result %0d unexpected: mag %0d end %0b",
                                           results_seen, m_axis_tdata, m_axis_tlast));
                end else begin
                    want = expected_edges.pop_front();
                    if (m_axis_tdata !== want.magnitude || m_axis_tlast !== want.frame_end)
                        note_failure($sformatf(
                            "result %0d mismatch: expected mag %0d end %0b, got mag %0d end %0b",
                            results_seen, want.magnitude, want.frame_end,
                            m_axis_tdata, m_axis_tlast));
                end
            end
        end
    end

    // Watchdog: end the run if no transaction of any kind happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned random_start;
        logic [CFG_W-1:0] w_val, h_val;

        // Predictor starts at the block's reset state
        for (int i = 0; i < MAX_W; i++) begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            window_px[i] = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame size: three rows and part of a fourth at 640 wide. This
        // also fills both line stores for all columns below 640. Ask for one
        // long receiver hold-off while results are flowing.
        queue_pixels(2 * 640, 640, TEX_SOFT);
        queue_pixels(640 + 100, 640, TEX_NOISE);
        hold_off_requests++;
        wait_for_quiet();

        // Shrink both sizes mid-frame below the current position: the next
        // pixel still yields an ordinary result, then wraps to a new frame.
        write_frame_reg(CFG_FRAME_WIDTH, 12'd50);
        write_frame_reg(CFG_FRAME_HEIGHT, 12'd3);
        queue_pixels(pixels_to_frame_start(), 50, TEX_NOISE);

        // Smallest frame, hand-picked windows around the saturation point
        wait_for_quiet();
        write_frame_reg(CFG_FRAME_WIDTH, 12'd3);
        write_frame_reg(CFG_FRAME_HEIGHT, 12'd3);
        for (int i = 0; i < 27; i++)
            pixel_queue.push_back(PROBE_PIXELS[i]);
        pixels_queued += 27;

        // Grow both sizes, the second time mid-frame; the wider columns were written above
        wait_for_quiet();
        write_frame_reg(CFG_FRAME_WIDTH, 12'd8);
        write_frame_reg(CFG_FRAME_HEIGHT, 12'd5);
        queue_pixels(2 * 8 + 4, 8, TEX_RAMP);
        wait_for_quiet();
        write_frame_reg(CFG_FRAME_WIDTH, 12'd12);
        write_frame_reg(CFG_FRAME_HEIGHT, 12'd7);
        queue_pixels(pixels_to_frame_start(), 12, TEX_STEP);

        // Register values below range clamp up to 3
        run_frames(12'd0, 12'd0, 1);
        run_frames(12'd2, 12'd2, 2);

        // Width extremes: all-ones clamps to the widest row, then the widest
        // row written as is, streamed with no idling on either side.
        hold_off_requests++;
        run_frames(12'd4095, 12'd3, 1);
        steady_flow = 1'b1;
        run_frames(12'd2048, 12'd3, 1);
        wait_for_quiet();
        steady_flow = 1'b0;

        // Tallest frame, narrowest row
        run_frames(12'd3, 12'd4095, 1);

        // Random small frames, now and then an out-of-range or wider setting
        random_start = pixels_queued;
        while (pixels_queued - random_start < RANDOM_PIXELS) begin
            if ($urandom_range(9) == 0)
                w_val = $urandom_range(0, 2);
            else if ($urandom_range(7) == 0)
                w_val = $urandom_range(21, 64);
            else
                w_val = $urandom_range(3, 20);
            h_val = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            run_frames(w_val, h_val, $urandom_range(1, 3));
        end

        wait_for_quiet();
        if (failures == 0 && expected_edges.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
